### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge while out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Implication checked at every clock edge while out of reset.
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("assertion failed");

`endif

### rtl/core/yaz0_pkg.sv
// ----------------------------------------------------------------------------
// yaz0_pkg: shared types and constants of the Yaz0 decompressor.
// Holds the payload structs, the command passed front to back and the FSMs.
// ----------------------------------------------------------------------------
package yaz0_pkg;

	localparam int WIN_AW     = 12;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	localparam logic [7:0] REF_ADD3 = 8'h12;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_first;
	} in_item_t;

	typedef struct packed {
		logic [63:0] out_bytes;
		logic [3:0]  out_valid;
		logic        out_last;
		logic [1:0]  out_status;
	} out_item_t;

	localparam logic [1:0] ST_DATA  = 2'd0;
	localparam logic [1:0] ST_MAGIC = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef enum logic [1:0] {
		CMD_JOB,
		CMD_LIT,
		CMD_COPY,
		CMD_STAT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  data;
		logic [8:0]  len;
		logic [11:0] ref_dist;
		logic        last;
		logic [1:0]  status;
	} cmd_t;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_GROUP,
		PH_ITEM,
		PH_REF2,
		PH_REF3,
		PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_RD,
		BK_PUT,
		BK_FLUSH,
		BK_STAT
	} bk_state_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] r;
		begin
			case (idx)
				2'd0: r = 8'h59;
				2'd1: r = 8'h61;
				2'd2: r = 8'h7A;
				default: r = 8'h30;
			endcase
			return r;
		end
	endfunction

endpackage

### rtl/core/yaz0_lz_decompressor_top.sv
// Flow: a literal's byte passes through the command queue to the executor, which writes
// it to the history and packs it in its put state, then enters the flush state. A copy is
// taken from the queue, then each decoded byte is read and then put, as set by the
// history's single read port; each packing flush carries up to 8 bytes.
// Results leave through a registered output stage.
// Reset: arst_n clears all control state; the history holds no reset value.
// ----------------------------------------------------------------------------
// yaz0_lz_decompressor_top: Yaz0 stream decompressor
// Front end parses the compressed stream into commands, a short queue decouples
// it from the executor, which rebuilds bytes from a 4096-byte history.
// ----------------------------------------------------------------------------
module yaz0_lz_decompressor_top
	import yaz0_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [31:0] cfg_wdata
);

	// Configuration registers. They are to be written only while the block is idle (the
	// block itself does not enforce this), so both halves may read them directly.
	logic [31:0] skip_q;
	logic [31:0] emit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= '0;
			emit_q <= '1;
		end else if (cfg_we) begin
			if (cfg_idx) begin
				emit_q <= cfg_wdata;
			end else begin
				skip_q <= cfg_wdata;
			end
		end
	end

	// Commands from the parser to the executor.
	logic cmd_push;
	cmd_t cmd_w;
	logic q_pop;
	cmd_t q_cmd;
	logic q_empty;
	logic q_full;

	yaz0_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.skip_bytes (skip_q),
		.emit_bytes (emit_q),
		.q_full     (q_full),
		.cmd_push   (cmd_push),
		.cmd        (cmd_w)
	);

	yaz0_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_w),
		.pop    (q_pop),
		.rdata  (q_cmd),
		.empty  (q_empty),
		.full   (q_full)
	);

	// The executor owns the history and the output register.
	yaz0_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.skip_bytes (skip_q),
		.q_empty    (q_empty),
		.q_cmd      (q_cmd),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

### rtl/core/yaz0_front.sv
// ----------------------------------------------------------------------------
// yaz0_front: header check and token parser
// Takes compressed bytes and turns them into job, literal, copy and status
// commands. Copy lengths are clamped so that the job ends at the right byte.
// ----------------------------------------------------------------------------
module yaz0_front
	import yaz0_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	input  logic [31:0] skip_bytes,
	input  logic [31:0] emit_bytes,
	input  logic        q_full,
	output logic        cmd_push,
	output cmd_t        cmd
);

	phase_t      phase_q, phase_d;
	logic [3:0]  hidx_q, hidx_d;
	logic        mok_q, mok_d;
	logic [31:0] dsize_q, dsize_d;
	logic [31:0] rem_q, rem_d;
	logic [7:0]  gbits_q, gbits_d;
	logic [3:0]  gleft_q, gleft_d;
	logic [7:0]  refhi_q, refhi_d;
	// Low byte of a three-byte reference, kept until the length byte arrives.
	logic [7:0]  dlo_q;

	logic        acc;
	logic [32:0] sum33;
	logic [31:0] lim;
	logic [8:0]  len;
	logic [8:0]  n;
	logic        lastc;
	phase_t      ph;
	logic [3:0]  hidx;
	logic        mok;
	logic [31:0] dsz;
	logic [7:0]  b;

	assign in_stall = q_full;
	assign acc      = in_valid && !q_full;
	assign b        = in_data.in_byte;
	assign sum33    = {1'b0, skip_bytes} + {1'b0, emit_bytes};
	assign lim      = (sum33 < {1'b0, dsize_q}) ? sum33[31:0] : dsize_q;

	always_comb begin
		ph   = in_data.in_first ? PH_HEADER : phase_q;
		hidx = in_data.in_first ? 4'd0 : hidx_q;
		mok  = in_data.in_first ? 1'b1 : mok_q;
		dsz  = in_data.in_first ? 32'd0 : dsize_q;

		phase_d  = phase_q;
		hidx_d   = hidx_q;
		mok_d    = mok_q;
		dsize_d  = dsize_q;
		rem_d    = rem_q;
		gbits_d  = gbits_q;
		gleft_d  = gleft_q;
		refhi_d  = refhi_q;
		cmd_push = 1'b0;
		cmd      = '0;
		cmd.kind = CMD_LIT;
		len      = 9'd1;
		n        = 9'd0;
		lastc    = 1'b0;

		// Clamp a run to what is left of the job.
		if (ph == PH_REF3) begin
			len = {1'b0, b} + {1'b0, REF_ADD3};
		end else if (ph == PH_REF2) begin
			len = {5'd0, refhi_q[7:4]} + 9'd2;
		end
		if (rem_q < {23'd0, len}) begin
			n = rem_q[8:0];
		end else begin
			n = len;
		end
		lastc = (rem_q <= {23'd0, len});

		if (acc) begin
			phase_d = ph;
			hidx_d  = hidx;
			mok_d   = mok;
			dsize_d = dsz;
			unique case (ph)
				PH_HEADER: begin
					if (hidx < 4'd4) begin
						if (b != magic_byte(hidx[1:0])) begin
							mok_d = 1'b0;
						end
					end else if (hidx < 4'd8) begin
						dsize_d = {dsz[23:0], b};
					end
					hidx_d = hidx + 4'd1;
					if (hidx == 4'd15) begin
						cmd_push = 1'b1;
						rem_d    = lim;
						gbits_d  = '0;
						gleft_d  = '0;
						if (!mok) begin
							cmd.kind   = CMD_STAT;
							cmd.status = ST_MAGIC;
							phase_d    = PH_DONE;
						end else if (emit_bytes == 32'd0 || skip_bytes > dsize_q) begin
							cmd.kind   = CMD_STAT;
							cmd.status = ST_RANGE;
							phase_d    = PH_DONE;
						end else begin
							cmd.kind = CMD_JOB;
							cmd.last = (dsize_q == 32'd0);
							phase_d  = (dsize_q == 32'd0) ? PH_DONE : PH_GROUP;
						end
					end
				end
				PH_GROUP: begin
					gbits_d = b;
					gleft_d = 4'd8;
					phase_d = PH_ITEM;
				end
				PH_ITEM, PH_REF2, PH_REF3: begin
					if (ph == PH_ITEM && !gbits_q[7]) begin
						refhi_d = b;
						phase_d = PH_REF2;
					end else if (ph == PH_REF2 && refhi_q[7:4] == 4'd0) begin
						// A zero length nibble means a third byte holds the length.
						phase_d = PH_REF3;
					end else begin
						cmd_push     = 1'b1;
						cmd.kind     = (ph == PH_ITEM) ? CMD_LIT : CMD_COPY;
						cmd.data     = b;
						cmd.len      = (ph == PH_ITEM) ? 9'd1 : n;
						cmd.last     = (ph == PH_ITEM) ? (rem_q == 32'd1) : lastc;
						cmd.ref_dist = {refhi_q[3:0], (ph == PH_REF3) ? dlo_q : b};
						rem_d        = rem_q - ((ph == PH_ITEM) ? 32'd1 : {23'd0, n});
						gbits_d      = {gbits_q[6:0], 1'b0};
						gleft_d      = (gleft_q != 4'd0) ? gleft_q - 4'd1 : 4'd0;
						if (cmd.last) begin
							phase_d = PH_DONE;
						end else if (gleft_q > 4'd1) begin
							phase_d = PH_ITEM;
						end else begin
							phase_d = PH_GROUP;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc && ph == PH_REF2) begin
			dlo_q <= b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hidx_q  <= '0;
			mok_q   <= 1'b1;
			dsize_q <= '0;
			rem_q   <= '0;
			gbits_q <= '0;
			gleft_q <= '0;
			refhi_q <= '0;
		end else begin
			phase_q <= phase_d;
			hidx_q  <= hidx_d;
			mok_q   <= mok_d;
			dsize_q <= dsize_d;
			rem_q   <= rem_d;
			gbits_q <= gbits_d;
			gleft_q <= gleft_d;
			refhi_q <= refhi_d;
		end
	end

endmodule

### rtl/core/yaz0_fifo.sv
// ----------------------------------------------------------------------------
// yaz0_fifo: command queue between parser and executor
// A small register queue that lets either side stall on its own.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module yaz0_fifo
	import yaz0_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	input  logic pop,
	output cmd_t rdata,
	output logic empty,
	output logic full
);

	cmd_t               slot_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wp_q;
	logic [FIFO_AW-1:0] rp_q;
	logic [FIFO_AW:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
	assign rdata = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
		end
	end

	`ASSERT_IMPLY(a_no_overflow, clk, arst_n, full, !push || pop)
	`ASSERT_IMPLY(a_no_underflow, clk, arst_n, empty, !pop)
	`ASSERT_ALWAYS(a_cnt_range, clk, arst_n, cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH))

endmodule

### rtl/core/yaz0_back.sv
// ----------------------------------------------------------------------------
// yaz0_back: command executor
// Writes decoded bytes to the history, reads copy sources, drops skipped
// bytes and packs the rest into results; a status command gives a status result.
// ----------------------------------------------------------------------------
module yaz0_back
	import yaz0_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] skip_bytes,
	input  logic        q_empty,
	input  cmd_t        q_cmd,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data
);

	logic [7:0] hist_q [2**WIN_AW];
	logic [7:0] rdat_q;

	bk_state_t   st_q, st_d;
	logic [WIN_AW-1:0] wp_q;
	logic [31:0] prod_q;
	logic [8:0]  rem_q;
	logic [11:0] dist_q;
	logic        last_q;
	logic [63:0] pack_q;
	logic [3:0]  pcnt_q;
	logic [7:0]  lit_q;
	logic        sel_lit_q;
	logic [1:0]  stat_q;
	logic        ovld_q;
	out_item_t   out_q;

	logic        out_free;
	logic        push;
	out_item_t   push_d;
	logic [7:0]  byte_w;
	logic        keep;
	logic [WIN_AW-1:0] rd_addr;

	assign out_free  = !ovld_q || !out_stall;
	assign out_valid = ovld_q;
	assign out_data  = out_q;
	assign byte_w    = sel_lit_q ? lit_q : rdat_q;
	assign keep      = (prod_q >= skip_bytes);
	assign rd_addr   = wp_q - dist_q - WIN_AW'(1);

	always_comb begin
		st_d   = st_q;
		q_pop  = 1'b0;
		push   = 1'b0;
		push_d = '0;
		unique case (st_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					unique case (q_cmd.kind)
						CMD_JOB:  st_d = q_cmd.last ? BK_FLUSH : BK_IDLE;
						CMD_LIT:  st_d = BK_PUT;
						CMD_COPY: st_d = BK_RD;
						default:  st_d = BK_STAT;
					endcase
				end
			end
			BK_RD: st_d = BK_PUT;
			BK_PUT: begin
				if ((pcnt_q + 4'(keep)) == 4'd8 || rem_q == 9'd1) begin
					st_d = BK_FLUSH;
				end else begin
					st_d = BK_RD;
				end
			end
			BK_FLUSH: begin
				if (pcnt_q == 4'd0 && !(rem_q == 9'd0 && last_q)) begin
					st_d = (rem_q == 9'd0) ? BK_IDLE : BK_RD;
				end else if (out_free) begin
					push              = 1'b1;
					push_d.out_bytes  = pack_q;
					push_d.out_valid  = pcnt_q;
					push_d.out_last   = last_q && (rem_q == 9'd0);
					push_d.out_status = ST_DATA;
					st_d              = (rem_q == 9'd0) ? BK_IDLE : BK_RD;
				end
			end
			BK_STAT: begin
				if (out_free) begin
					push              = 1'b1;
					push_d.out_last   = 1'b1;
					push_d.out_status = stat_q;
					st_d              = BK_IDLE;
				end
			end
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_q == BK_RD) begin
			rdat_q <= hist_q[rd_addr];
		end
		if (st_q == BK_PUT) begin
			hist_q[wp_q] <= byte_w;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= push_d;
		end
		if (q_pop) begin
			lit_q     <= q_cmd.data;
			dist_q    <= q_cmd.ref_dist;
			stat_q    <= q_cmd.status;
			sel_lit_q <= (q_cmd.kind == CMD_LIT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= BK_IDLE;
			ovld_q <= 1'b0;
			wp_q   <= '0;
			prod_q <= '0;
			rem_q  <= '0;
			last_q <= 1'b0;
			pack_q <= '0;
			pcnt_q <= '0;
		end else begin
			st_q <= st_d;
			if (push) begin
				ovld_q <= 1'b1;
				pack_q <= '0;
				pcnt_q <= '0;
			end else if (!out_stall) begin
				ovld_q <= 1'b0;
			end
			if (q_pop) begin
				rem_q  <= (q_cmd.kind == CMD_JOB || q_cmd.kind == CMD_STAT) ? 9'd0 : q_cmd.len;
				last_q <= q_cmd.last;
				if (q_cmd.kind == CMD_JOB) begin
					wp_q   <= '0;
					prod_q <= '0;
					pack_q <= '0;
					pcnt_q <= '0;
				end
			end
			if (st_q == BK_PUT) begin
				wp_q   <= wp_q + 1'b1;
				prod_q <= prod_q + 32'd1;
				rem_q  <= rem_q - 9'd1;
				if (keep) begin
					pack_q[pcnt_q[2:0]*8 +: 8] <= byte_w;
					pcnt_q <= pcnt_q + 4'd1;
				end
			end
		end
	end

endmodule
